### hdl/nearest_heater_heat_lookup_defines.svh
// Assertion macros shared by the nearest-heater lookup RTL.
// Included by nhhl_ctrl and nhhl_datapath; no other dependencies.
`ifndef NEAREST_HEATER_HEAT_LOOKUP_DEFINES_SVH
`define NEAREST_HEATER_HEAT_LOOKUP_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante
`define NHHL_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nhhl: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define NHHL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nhhl: next-cycle check failed");

// Check that expr never holds
`define NHHL_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("nhhl: forbidden condition seen");

`else

`define NHHL_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define NHHL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`define NHHL_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

### hdl/nhhl_pkg.sv
// Types, constants and the falloff table of the nearest-heater lookup.
// Used by nhhl_ctrl, nhhl_datapath and the top level; no dependencies.
package nhhl_pkg;

    localparam int MAX_HEATERS_DEF   = 16;
    localparam int COORD_WIDTH_DEF   = 8;
    localparam int POWER_W           = 16;
    localparam int COEF_W            = 7;
    localparam int HEAT_W            = POWER_W + COEF_W;
    localparam int INDEX_W           = 4;
    localparam int CFG_W             = 5;
    localparam int FALLOFF_REACH     = 6;
    localparam logic [CFG_W-1:0] NUM_HEATERS_RESET = 5'd10;

    // Request kinds
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_DRAIN  = 4'b0100,
        ST_FINISH = 4'b1000
    } nhhl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_wr;
        logic query_start;
        logic rd_en;
        logic finish;
    } nhhl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } nhhl_sts_t;

    // Table slot index width, at least one bit
    function automatic int idx_width(input int n);
        return (n > 1) ? $clog2(n) : 1;
    endfunction

    // Falloff coefficient in hundredths by Chebyshev distance and diagonal flag
    function automatic logic [COEF_W-1:0] falloff_coef(input logic [2:0] m,
                                                       input logic diag);
        logic [COEF_W-1:0] c;
        unique case (m)
            3'd0:    c = 7'd100;
            3'd1:    c = 7'd85;
            3'd2:    c = diag ? 7'd75 : 7'd85;
            3'd3:    c = 7'd75;
            3'd4:    c = diag ? 7'd65 : 7'd75;
            3'd5:    c = diag ? 7'd60 : 7'd65;
            3'd6:    c = diag ? 7'd0  : 7'd60;
            default: c = 7'd0;
        endcase
        return c;
    endfunction

endpackage

### hdl/nearest_heater_heat_lookup.sv
// Nearest-heater heat lookup. A load request (action 0) writes one heater
// slot and leaves the block idle. A query request (action 1) reads the
// first num_heaters slots (clamped to 1..MAX_HEATERS) from the heater
// table, one slot per cycle through its single read port, and keeps the
// nearest by squared distance (lowest slot on ties); the answer is the
// heater's power times the falloff coefficient in hundredths. A query
// occupies the block through the table scan, a two-stage distance pipe
// (read and distance stages) and the write of the output register.
// The result sits in an output register, so a waiting result blocks only
// the completion of the following query. Reading a slot never loaded gives
// undefined fields.
// Depends on nhhl_pkg, nhhl_ctrl and nhhl_datapath.

module nearest_heater_heat_lookup
    import nhhl_pkg::*;
#(
    parameter int MAX_HEATERS = MAX_HEATERS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_W-1:0]       num_heaters,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic                   action,
    input  logic [INDEX_W-1:0]     heater_index,
    input  logic [COORD_WIDTH-1:0] heater_x,
    input  logic [COORD_WIDTH-1:0] heater_y,
    input  logic [POWER_W-1:0]     heater_power,
    input  logic [COORD_WIDTH-1:0] point_x,
    input  logic [COORD_WIDTH-1:0] point_y,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [HEAT_W-1:0]      heat_hundredths,
    output logic [INDEX_W-1:0]     nearest_index
);

    localparam int IDX_W = idx_width(MAX_HEATERS);

    nhhl_cmd_t        cmd;
    nhhl_sts_t        sts;
    logic [IDX_W-1:0] rd_addr;

    nhhl_ctrl #(
        .MAX_HEATERS (MAX_HEATERS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .num_heaters (num_heaters),
        .sts         (sts),
        .cmd         (cmd),
        .rd_addr     (rd_addr)
    );

    nhhl_datapath #(
        .MAX_HEATERS (MAX_HEATERS),
        .COORD_WIDTH (COORD_WIDTH)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .rd_addr         (rd_addr),
        .heater_index    (heater_index),
        .heater_x        (heater_x),
        .heater_y        (heater_y),
        .heater_power    (heater_power),
        .point_x         (point_x),
        .point_y         (point_y),
        .sts             (sts),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .heat_hundredths (heat_hundredths),
        .nearest_index   (nearest_index)
    );

endmodule

### hdl/nhhl_ctrl.sv
// Controller of the nearest-heater lookup: request sequencing, table scan
// counter and the num_heaters register. Depends on nhhl_pkg and the defines.
`include "nearest_heater_heat_lookup_defines.svh"

module nhhl_ctrl
    import nhhl_pkg::*;
#(
    parameter int MAX_HEATERS = MAX_HEATERS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic                              action,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [CFG_W-1:0]                  num_heaters,
    input  nhhl_sts_t                         sts,
    output nhhl_cmd_t                         cmd,
    output logic [idx_width(MAX_HEATERS)-1:0] rd_addr
);

    localparam int IDX_W = idx_width(MAX_HEATERS);

    nhhl_state_t      state_reg, state_next;
    logic [IDX_W-1:0] cnt_reg, cnt_next;
    logic [CFG_W-1:0] num_reg;
    logic [IDX_W-1:0] last_idx;
    logic             accept;

    // Hold the search count; writes must come only while idle, which the block itself does not enforce
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_reg <= NUM_HEATERS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            num_reg <= num_heaters;
        end
    end

    // Clamp the count to 1..MAX_HEATERS and take the last slot searched
    always_comb
    begin
        if (num_reg == '0)
        begin
            last_idx = '0;
        end
        else if (32'(num_reg) > MAX_HEATERS)
        begin
            last_idx = IDX_W'(MAX_HEATERS - 1);
        end
        else
        begin
            last_idx = IDX_W'(num_reg - 1'b1);
        end
    end

    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign rd_addr  = cnt_reg;

    // Sequence one request at a time
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        cmd.load_wr     = 1'b0;
        cmd.query_start = 1'b0;
        cmd.rd_en       = 1'b0;
        cmd.finish      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && action == ACT_LOAD)
                begin
                    cmd.load_wr = 1'b1;
                end
                else if (accept && action == ACT_QUERY)
                begin
                    cmd.query_start = 1'b1;
                    cnt_next        = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (cnt_reg == last_idx)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + IDX_W'(1);
                end
            end
            ST_DRAIN:
            begin
                if (!sts.pipe_busy)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `NHHL_ASSERT_NEXT(a_query_starts_scan, clk, rst_n, cmd.query_start, state_reg == ST_SCAN)
    `NHHL_ASSERT_SAME(a_scan_in_range, clk, rst_n, state_reg == ST_SCAN, cnt_reg <= last_idx)
    `NHHL_ASSERT_SAME(a_finish_after_drain, clk, rst_n, cmd.finish, !sts.pipe_busy)

endmodule

### hdl/nhhl_datapath.sv
// Datapath of the nearest-heater lookup: heater table memory, distance
// pipeline, running minimum and heat output register. Depends on nhhl_pkg.
`include "nearest_heater_heat_lookup_defines.svh"

module nhhl_datapath
    import nhhl_pkg::*;
#(
    parameter int MAX_HEATERS = MAX_HEATERS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  nhhl_cmd_t                         cmd,
    input  logic [idx_width(MAX_HEATERS)-1:0] rd_addr,
    input  logic [INDEX_W-1:0]                heater_index,
    input  logic [COORD_WIDTH-1:0]            heater_x,
    input  logic [COORD_WIDTH-1:0]            heater_y,
    input  logic [POWER_W-1:0]                heater_power,
    input  logic [COORD_WIDTH-1:0]            point_x,
    input  logic [COORD_WIDTH-1:0]            point_y,
    output nhhl_sts_t                         sts,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [HEAT_W-1:0]                 heat_hundredths,
    output logic [INDEX_W-1:0]                nearest_index
);

    localparam int IDX_W = idx_width(MAX_HEATERS);
    localparam int ENT_W = 2 * COORD_WIDTH + POWER_W;
    localparam int DST_W = 2 * COORD_WIDTH + 1;

    logic [ENT_W-1:0]       table_mem [MAX_HEATERS];
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;

    logic [COORD_WIDTH-1:0] px_reg, py_reg;

    // Read stage
    logic [ENT_W-1:0]       rd_data_reg;
    logic [IDX_W-1:0]       s0_idx_reg;
    logic                   s0_vld_reg;

    // Distance stage
    logic [COORD_WIDTH-1:0] hx, hy, ax, ay;
    logic [POWER_W-1:0]     hp;
    logic [DST_W-1:0]       d_next;
    logic [DST_W-1:0]       d_reg;
    logic [COORD_WIDTH-1:0] ax_reg, ay_reg;
    logic [POWER_W-1:0]     pw_reg;
    logic [IDX_W-1:0]       s1_idx_reg;
    logic                   s1_vld_reg;

    // Running minimum
    logic                   take;
    logic [DST_W-1:0]       best_d_reg;
    logic [COORD_WIDTH-1:0] best_ax_reg, best_ay_reg;
    logic [POWER_W-1:0]     best_pw_reg;
    logic [IDX_W-1:0]       best_idx_reg;

    // Result
    logic                   near;
    logic [COORD_WIDTH-1:0] cheb;
    logic [COEF_W-1:0]      coef;
    logic [HEAT_W-1:0]      heat_next;
    logic [HEAT_W-1:0]      heat_reg;
    logic [INDEX_W-1:0]     nidx_reg;
    logic                   out_valid_reg;

    // Write a heater entry; drop slots beyond the table
    assign wr_en   = cmd.load_wr && (32'(heater_index) < MAX_HEATERS);
    assign wr_addr = IDX_W'(heater_index);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= {heater_x, heater_y, heater_power};
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= table_mem[rd_addr];
            s0_idx_reg  <= rd_addr;
        end
    end

    // Hold the queried point
    always_ff @(posedge clk)
    begin
        if (cmd.query_start)
        begin
            px_reg <= point_x;
            py_reg <= point_y;
        end
    end

    // Squared distance of the entry just read
    assign {hx, hy, hp} = rd_data_reg;
    assign ax     = (px_reg > hx) ? px_reg - hx : hx - px_reg;
    assign ay     = (py_reg > hy) ? py_reg - hy : hy - py_reg;
    assign d_next = (DST_W'(ax) * DST_W'(ax)) + (DST_W'(ay) * DST_W'(ay));

    always_ff @(posedge clk)
    begin
        if (s0_vld_reg)
        begin
            d_reg      <= d_next;
            ax_reg     <= ax;
            ay_reg     <= ay;
            pw_reg     <= hp;
            s1_idx_reg <= s0_idx_reg;
        end
    end

    // Advance the pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            s1_vld_reg <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= cmd.rd_en;
            s1_vld_reg <= s0_vld_reg;
        end
    end

    // Keep the nearest so far; strict compare leaves ties with the lower slot
    assign take = s1_vld_reg && ((s1_idx_reg == '0) || (d_reg < best_d_reg));

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_d_reg   <= d_reg;
            best_ax_reg  <= ax_reg;
            best_ay_reg  <= ay_reg;
            best_pw_reg  <= pw_reg;
            best_idx_reg <= s1_idx_reg;
        end
    end

    // Falloff coefficient and heat of the nearest heater
    assign near = (best_ax_reg <= COORD_WIDTH'(FALLOFF_REACH))
               && (best_ay_reg <= COORD_WIDTH'(FALLOFF_REACH));
    assign cheb = (best_ax_reg > best_ay_reg) ? best_ax_reg : best_ay_reg;
    assign coef = near ? falloff_coef(cheb[2:0], best_ax_reg == best_ay_reg) : '0;
    assign heat_next = HEAT_W'(best_pw_reg) * HEAT_W'(coef);

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            heat_reg <= heat_next;
            nidx_reg <= INDEX_W'(best_idx_reg);
        end
    end

    // Hold the result until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign sts.pipe_busy  = s0_vld_reg || s1_vld_reg;
    assign sts.out_free   = !out_valid_reg || !out_stall;
    assign out_valid      = out_valid_reg;
    assign heat_hundredths = heat_reg;
    assign nearest_index  = nidx_reg;

    `NHHL_ASSERT_SAME(a_no_overwrite, clk, rst_n, cmd.finish, !out_valid_reg || !out_stall)
    `NHHL_ASSERT_NEXT(a_pipe_advance, clk, rst_n, s0_vld_reg, s1_vld_reg)
    `NHHL_ASSERT_SAME(a_result_from_finish, clk, rst_n, $rose(out_valid_reg), $past(cmd.finish))

endmodule

### tb/nhhl_checker.sv
// Checker for the nearest-heater lookup: mirrors the heater table and the slot
// count, predicts the answer to every query request and compares it with the output.
// Depends on nhhl_pkg.
`timescale 1ns / 1ps

module nhhl_checker
    import nhhl_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_W-1:0]       num_heaters,
    input  logic                   in_valid,
    input  logic                   in_stall,
    input  logic                   action,
    input  logic [INDEX_W-1:0]     heater_index,
    input  logic [COORD_WIDTH-1:0] heater_x,
    input  logic [COORD_WIDTH-1:0] heater_y,
    input  logic [POWER_W-1:0]     heater_power,
    input  logic [COORD_WIDTH-1:0] point_x,
    input  logic [COORD_WIDTH-1:0] point_y,
    input  logic                   out_valid,
    input  logic                   out_stall,
    input  logic [HEAT_W-1:0]      heat_hundredths,
    input  logic [INDEX_W-1:0]     nearest_index,
    output int                     errors,
    output int                     pending
);

    typedef struct packed {
        logic [HEAT_W-1:0]  heat;
        logic [INDEX_W-1:0] slot;
    } heat_answer_t;

    heat_answer_t           answers_due [$];
    logic [COORD_WIDTH-1:0] known_x [MAX_HEATERS_DEF];
    logic [COORD_WIDTH-1:0] known_y [MAX_HEATERS_DEF];
    logic [POWER_W-1:0]     known_p [MAX_HEATERS_DEF];
    logic [CFG_W-1:0]       slots_searched;

    // Falloff in hundredths from the axis offsets; zero beyond reach
    function automatic int coef_for(input longint ax, input longint ay);
        longint m;
        bit     diag;
        m    = (ax > ay) ? ax : ay;
        diag = (ax == ay);
        if (m > FALLOFF_REACH)
            return 0;
        case (m)
            0:       return 100;
            1:       return 85;
            2:       return diag ? 75 : 85;
            3:       return 75;
            4:       return diag ? 65 : 75;
            5:       return diag ? 60 : 65;
            default: return diag ? 0 : 60;
        endcase
    endfunction

    // Search the active slots for the nearest heater and work out its heat
    function automatic heat_answer_t nearest_heat(input logic [COORD_WIDTH-1:0] px,
                                                  input logic [COORD_WIDTH-1:0] py);
        heat_answer_t ans;
        int           count;
        int           best;
        longint       best_d;
        longint       dx;
        longint       dy;
        longint       d;
        count = slots_searched;
        if (count == 0)
            count = 1;
        if (count > MAX_HEATERS_DEF)
            count = MAX_HEATERS_DEF;
        best   = 0;
        best_d = 0;
        for (int i = 0; i < count; i++) begin
            dx = longint'(px) - longint'(known_x[i]);
            dy = longint'(py) - longint'(known_y[i]);
            if (dx < 0) dx = -dx;
            if (dy < 0) dy = -dy;
            d = dx * dx + dy * dy;
            // strict compare keeps the lowest slot on a tie
            if (i == 0 || d < best_d) begin
                best_d = d;
                best   = i;
            end
        end
        dx = longint'(px) - longint'(known_x[best]);
        dy = longint'(py) - longint'(known_y[best]);
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        ans.slot = INDEX_W'(best);
        ans.heat = HEAT_W'(longint'(known_p[best]) * coef_for(dx, dy));
        return ans;
    endfunction

    // Sample at the falling edge: every handshake is settled by then
    always @(negedge clk) begin : watch
        heat_answer_t want;
        if (!rst_n) begin
            errors         = 0;
            slots_searched = NUM_HEATERS_RESET;
            answers_due.delete();
            for (int i = 0; i < MAX_HEATERS_DEF; i++) begin
                known_x[i] = '0;
                known_y[i] = '0;
                known_p[i] = '0;
            end
        end else begin
            if (cfg_valid === 1'b1 && cfg_ready === 1'b1)
                slots_searched = num_heaters;

            // Take an accepted request: store a heater or queue an answer
            if (in_valid === 1'b1 && in_stall === 1'b0) begin
                if (action == ACT_LOAD) begin
                    if (int'(heater_index) < MAX_HEATERS_DEF) begin
                        known_x[heater_index] = heater_x;
                        known_y[heater_index] = heater_y;
                        known_p[heater_index] = heater_power;
                    end
                end else begin
                    answers_due.push_back(nearest_heat(point_x, point_y));
                end
            end

            // Compare an accepted result with the oldest queued answer
            if (out_valid === 1'b1 && out_stall === 1'b0) begin
                if (answers_due.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with no query waiting: heat %0d index %0d",
                                 $realtime, heat_hundredths, nearest_index);
                end else begin
                    want = answers_due.pop_front();
                    if (heat_hundredths !== want.heat || nearest_index !== want.slot) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch: heat exp %0d got %0d, index exp %0d got %0d",
                                     $realtime, want.heat, heat_hundredths,
                                     want.slot, nearest_index);
                    end
                end
            end
        end
        pending = answers_due.size();
    end

endmodule

### tb/nearest_heater_heat_lookup_tb.sv
// Top of the nearest-heater lookup testbench: clock, reset, request and
// stall generation, slot-count changes between phases, and the verdict.
// Depends on nhhl_pkg, nearest_heater_heat_lookup and nhhl_checker.
`timescale 1ns / 1ps

module nearest_heater_heat_lookup_tb;
    import nhhl_pkg::*;

    localparam int CW           = COORD_WIDTH_DEF;
    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 240;
    localparam int HOLD_CYCLES  = 400;

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic                   cfg_ready;
    logic [CFG_W-1:0]       num_heaters  = NUM_HEATERS_RESET;
    logic                   in_valid     = 1'b0;
    logic                   in_stall;
    logic                   action       = ACT_LOAD;
    logic [INDEX_W-1:0]     heater_index = '0;
    logic [CW-1:0]          heater_x     = '0;
    logic [CW-1:0]          heater_y     = '0;
    logic [POWER_W-1:0]     heater_power = '0;
    logic [CW-1:0]          point_x      = '0;
    logic [CW-1:0]          point_y      = '0;
    logic                   out_valid;
    logic                   out_stall    = 1'b0;
    logic [HEAT_W-1:0]      heat_hundredths;
    logic [INDEX_W-1:0]     nearest_index;

    int                     errors;
    int                     pending;

    // Stimulus-side record of what has been loaded
    logic [MAX_HEATERS_DEF-1:0] loaded = '0;
    logic [CW-1:0]              slot_x [MAX_HEATERS_DEF];
    logic [CW-1:0]              slot_y [MAX_HEATERS_DEF];
    int                         cfg_now = NUM_HEATERS_RESET;
    int                         phase_cfg [PHASES] = '{16, 1, 0, 31, 7, 16, 12, 2};

    logic                   calm        = 1'b0;
    logic                   pressure_go = 1'b0;
    logic                   hold_off    = 1'b0;
    int                     stall_left  = 0;

    nearest_heater_heat_lookup u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .num_heaters     (num_heaters),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .heater_index    (heater_index),
        .heater_x        (heater_x),
        .heater_y        (heater_y),
        .heater_power    (heater_power),
        .point_x         (point_x),
        .point_y         (point_y),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .heat_hundredths (heat_hundredths),
        .nearest_index   (nearest_index)
    );

    nhhl_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .num_heaters     (num_heaters),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .action          (action),
        .heater_index    (heater_index),
        .heater_x        (heater_x),
        .heater_y        (heater_y),
        .heater_power    (heater_power),
        .point_x         (point_x),
        .point_y         (point_y),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .heat_hundredths (heat_hundredths),
        .nearest_index   (nearest_index),
        .errors          (errors),
        .pending         (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    // Random idle length: mostly none or short, now and then long
    function automatic int idle_len();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Coordinate either in a small crowded patch or anywhere on the plate
    function automatic logic [CW-1:0] pick_coord();
        if ($urandom_range(0, 99) < 40)
            return CW'(100 + $urandom_range(0, 15));
        return CW'($urandom());
    endfunction

    // Receiver: random stalls, forced high during the long hold-off
    always @(posedge clk or negedge rst_n) begin : rx_stall
        int n;
        if (!rst_n) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (hold_off) begin
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else begin
            n = ($urandom_range(0, 3) == 0) ? idle_len() : 0;
            out_stall  <= (n > 0);
            stall_left <= (n > 0) ? n - 1 : 0;
        end
    end

    // Hold the output off long enough to back the block up to its input
    initial begin : long_hold
        wait (pressure_go);
        repeat ($urandom_range(20, 80)) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    // Offer one request after a random gap and wait until it is taken
    task automatic send_request(input logic act, input logic [INDEX_W-1:0] slot,
                                input logic [CW-1:0] hx, input logic [CW-1:0] hy,
                                input logic [POWER_W-1:0] hp,
                                input logic [CW-1:0] px, input logic [CW-1:0] py);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        action       <= act;
        heater_index <= slot;
        heater_x     <= hx;
        heater_y     <= hy;
        heater_power <= hp;
        point_x      <= px;
        point_y      <= py;
        do @(negedge clk); while (in_stall !== 1'b0);
        @(posedge clk);
        if (act == ACT_LOAD) begin
            loaded[slot] = 1'b1;
            slot_x[slot] = hx;
            slot_y[slot] = hy;
        end
    endtask

    task automatic load_heater(input int slot, input logic [CW-1:0] hx,
                               input logic [CW-1:0] hy, input logic [POWER_W-1:0] hp);
        send_request(ACT_LOAD, INDEX_W'(slot), hx, hy, hp, CW'($urandom()), CW'($urandom()));
    endtask

    task automatic query_point(input logic [CW-1:0] px, input logic [CW-1:0] py);
        send_request(ACT_QUERY, INDEX_W'($urandom()), CW'($urandom()), CW'($urandom()),
                     POWER_W'($urandom()), px, py);
    endtask

    // Drain, let the block settle, then write a new slot count
    task automatic set_slot_count(input int value);
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (25) @(posedge clk);
        cfg_valid   <= 1'b1;
        num_heaters <= CFG_W'(value);
        do @(negedge clk); while (cfg_ready !== 1'b1);
        @(posedge clk);
        cfg_valid <= 1'b0;
        cfg_now = value;
    endtask

    // One random request; load any slot still needed before querying
    task automatic random_request();
        int              active;
        int              missing;
        int              s;
        int              r;
        logic [CW-1:0]   x;
        logic [CW-1:0]   y;
        logic [POWER_W-1:0] p;
        active = (cfg_now == 0) ? 1 : ((cfg_now > MAX_HEATERS_DEF) ? MAX_HEATERS_DEF : cfg_now);
        missing = -1;
        for (int i = active - 1; i >= 0; i--)
            if (!loaded[i])
                missing = i;
        r = $urandom_range(0, 99);
        if (missing >= 0 || r < 25) begin
            s = (missing >= 0) ? missing : $urandom_range(0, MAX_HEATERS_DEF - 1);
            r = $urandom_range(0, 99);
            p = (r < 10) ? '0 : ((r < 20) ? '1 : POWER_W'($urandom()));
            load_heater(s, pick_coord(), pick_coord(), p);
        end else begin
            if (r < 95) begin
                // land near an active heater, up to 7 from it on each axis
                s = $urandom_range(0, active - 1);
                x = slot_x[s] + CW'($urandom_range(0, 14)) - CW'(7);
                y = slot_y[s] + CW'($urandom_range(0, 14)) - CW'(7);
            end else begin
                x = pick_coord();
                y = pick_coord();
            end
            query_point(x, y);
        end
    endtask

    initial begin : stimulus
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, a distance tie and each falloff step but distance 3
        load_heater(0, 8'd0, 8'd0, 16'hFFFF);
        load_heater(1, 8'd255, 8'd255, 16'hFFFF);
        load_heater(2, 8'd100, 8'd100, 16'd1000);
        load_heater(3, 8'd100, 8'd110, 16'd2000);
        load_heater(4, 8'd100, 8'd90, 16'd3000);
        load_heater(5, 8'd50, 8'd200, 16'd12345);
        load_heater(6, 8'd200, 8'd50, 16'd54321);
        load_heater(7, 8'd30, 8'd30, 16'd0);
        load_heater(8, 8'd170, 8'd170, 16'd40000);
        load_heater(9, 8'd60, 8'd120, 16'd1);
        query_point(8'd0, 8'd0);
        query_point(8'd255, 8'd255);
        query_point(8'd100, 8'd105);
        query_point(8'd170, 8'd170);
        query_point(8'd171, 8'd171);
        query_point(8'd172, 8'd172);
        query_point(8'd174, 8'd174);
        query_point(8'd175, 8'd175);
        query_point(8'd176, 8'd176);
        query_point(8'd172, 8'd170);
        query_point(8'd174, 8'd171);
        query_point(8'd175, 8'd172);
        query_point(8'd176, 8'd170);
        query_point(8'd177, 8'd170);
        query_point(8'd30, 8'd31);

        // Random phases, each under its own slot count
        phase_cfg[6] = $urandom_range(1, MAX_HEATERS_DEF);
        for (int ph = 0; ph < PHASES; ph++) begin
            set_slot_count(phase_cfg[ph]);
            calm <= (ph == 5);
            if (ph == 0)
                pressure_go <= 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                random_request();
        end

        // Drain and let the last result settle
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (40) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Give up if the run hangs
    initial begin : watchdog
        #12_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
